// ===== hw/rtl/bdat_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdat_pkg
// Shared types and constants for the chunked-body line-ending normalizer.
// ----------------------------------------------------------------------------
package bdat_pkg;

  // Queue depth between the front and back halves
  localparam int QUEUE_DEPTH = 2;

  localparam logic [30:0] SIZE_LIMIT_RESET = 31'd52428800;
  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
  localparam logic [31:0] MAX32 = 32'hFFFF_FFFF;
  localparam logic [7:0]  CH_LF = 8'h0A;
  localparam logic [7:0]  CH_CR = 8'h0D;
  localparam logic [7:0]  CH_NUL = 8'h00;

  typedef enum logic [1:0] {
    CMD_DATA   = 2'd0,
    CMD_EOD    = 2'd1,
    CMD_CLOSED = 2'd2,
    CMD_RDERR  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_SIZE   = 2'd1,
    ST_CLOSED = 2'd2,
    ST_PROTO  = 2'd3
  } status_t;

  // Counters reported with a message end
  typedef struct packed {
    logic [31:0] lines;
    logic [30:0] longest;
    logic [31:0] zeros;
    logic [31:0] size;
  } cnt_t;

  // One accepted item, as the back half replays it:
  // nbytes spool bytes first, then an optional end status
  typedef struct packed {
    logic [1:0] nbytes;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic       has_end;
    status_t    status;
    cnt_t       cnt;
  } rec_t;

endpackage
`default_nettype wire

// ===== hw/rtl/bdat_line_ending_normalizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdat_line_ending_normalizer
// Rewrites chunked message body bytes for the spool (CRLF and bare CR become
// LF) and reports line, zero-byte and size counters when the message ends.
// ----------------------------------------------------------------------------
// The front half takes one command per cycle whenever the record queue has
// room; each command yields zero to three results (spool bytes, then an end
// status). The back half delivers one result per cycle while the output is
// not stalled, so the output port sets the sustained rate; a CR that waits
// for its successor yields nothing.
// size_limit may be rewritten at any idle time and survives message ends.
// ----------------------------------------------------------------------------
module bdat_line_ending_normalizer import bdat_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [30:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_end,
  output logic [7:0]       out_byte,
  output logic [1:0]       end_status,
  output logic [31:0]      line_count,
  output logic [30:0]      longest_line,
  output logic [31:0]      zero_count,
  output logic [31:0]      total_size,
  output logic             last_of_run
);

  logic push, pop, q_full, q_empty;
  rec_t push_rec, head_rec;

  // Classify and update state
  bdat_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .data_byte   (data_byte),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_full      (q_full),
    .push        (push),
    .push_rec    (push_rec)
  );

  // Decouple the two halves
  bdat_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Expand records into results
  bdat_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_rec     (head_rec),
    .empty        (q_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_end       (is_end),
    .out_byte     (out_byte),
    .end_status   (end_status),
    .line_count   (line_count),
    .longest_line (longest_line),
    .zero_count   (zero_count),
    .total_size   (total_size),
    .last_of_run  (last_of_run)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/bdat_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdat_front
// Accepts commands, runs the line machine and counters, and pushes one
// record per item that yields any result.
// ----------------------------------------------------------------------------
module bdat_front import bdat_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  command,
  input  wire logic [7:0]  data_byte,
  input  wire logic        cfg_wr_en,
  input  wire logic [30:0] cfg_wr_data,
  input  wire logic        q_full,
  output logic             push,
  output rec_t             push_rec
);

  typedef enum logic [2:0] {
    PH_AFTER_LF = 3'b001,
    PH_MID      = 3'b010,
    PH_AFTER_CR = 3'b100
  } phase_t;

  phase_t      phase, phase_next;
  logic [30:0] size_limit;
  logic [30:0] line_len;
  logic [31:0] lines;
  logic [30:0] max_line;
  logic [31:0] zeros;
  logic [31:0] written;
  logic        last_lf;

  cmd_t        cmd;
  logic        accept, is_lf, is_cr, phase_cr;
  logic        e0, e0_lf, e1, e1_go, exc0, exc1, fin;
  logic [31:0] w1, w2, zeros_f, written_f, lines_f;
  logic [30:0] len_inc, len_f, max_f;
  logic        last_f;
  status_t     status;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Classify the item: which bytes go to the spool
  always_comb begin
    cmd      = cmd_t'(command);
    is_lf    = (data_byte == CH_LF);
    is_cr    = (data_byte == CH_CR);
    phase_cr = (phase == PH_AFTER_CR);
    e0       = 1'b0;
    e0_lf    = 1'b0;
    e1       = 1'b0;
    case (cmd)
      CMD_DATA: begin
        if (phase_cr) begin
          e0    = 1'b1;
          e0_lf = 1'b1;
          e1    = !is_lf && !is_cr;
        end else if (is_lf) begin
          e0    = 1'b1;
          e0_lf = 1'b1;
        end else if (!is_cr) begin
          e0    = 1'b1;
        end
      end
      CMD_EOD: begin
        e0    = !last_lf;
        e0_lf = 1'b1;
      end
      default: begin
        e0 = 1'b0;
      end
    endcase
    if (is_lf) begin
      phase_next = PH_AFTER_LF;
    end else if (is_cr) begin
      phase_next = PH_AFTER_CR;
    end else begin
      phase_next = PH_MID;
    end
  end

  // Counter arithmetic for up to two written bytes
  always_comb begin
    zeros_f = (cmd == CMD_DATA && data_byte == CH_NUL && zeros != MAX32) ?
              zeros + 32'd1 : zeros;
    w1      = (written == MAX32) ? written : written + 32'd1;
    w2      = (written >= MAX32 - 32'd1) ? MAX32 : written + 32'd2;
    exc0    = w1 > {1'b0, size_limit};
    exc1    = w2 > {1'b0, size_limit};
    e1_go   = e1 && !exc0;
    len_inc = (line_len == MAX31) ? line_len : line_len + 31'd1;

    written_f = !e0 ? written : (e1_go ? w2 : w1);
    last_f    = !e0 ? last_lf : (e1_go ? 1'b0 : e0_lf);
    if (e0 && e0_lf) begin
      max_f   = (line_len > max_line) ? line_len : max_line;
      lines_f = (lines == MAX32) ? lines : lines + 32'd1;
      len_f   = e1_go ? 31'd1 : '0;
    end else begin
      max_f   = max_line;
      lines_f = lines;
      len_f   = e0 ? len_inc : line_len;
    end

    fin = (cmd != CMD_DATA) || (e0 && exc0) || (e1_go && exc1);
    case (cmd)
      CMD_CLOSED: status = ST_CLOSED;
      CMD_RDERR:  status = ST_PROTO;
      CMD_EOD:    status = (e0 && exc0) ? ST_SIZE : ST_DONE;
      default:    status = ST_SIZE;
    endcase
  end

  // Build the record for the back half
  always_comb begin
    push                  = accept && (e0 || fin);
    push_rec.nbytes       = e0 ? (e1_go ? 2'd2 : 2'd1) : 2'd0;
    push_rec.byte0        = e0_lf ? CH_LF : data_byte;
    push_rec.byte1        = data_byte;
    push_rec.has_end      = fin;
    push_rec.status       = status;
    push_rec.cnt.lines    = lines_f;
    push_rec.cnt.longest  = max_f;
    push_rec.cnt.zeros    = zeros_f;
    push_rec.cnt.size     = written_f;
  end

  // Hold the size limit
  always_ff @(posedge clk) begin
    if (rst) begin
      size_limit <= SIZE_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      size_limit <= cfg_wr_data;
    end
  end

  // Advance the line state; clear it when the message ends
  always_ff @(posedge clk) begin
    if (rst || (accept && fin)) begin
      phase    <= PH_AFTER_LF;
      line_len <= '0;
      lines    <= '0;
      max_line <= '0;
      zeros    <= '0;
      written  <= '0;
      last_lf  <= 1'b1;
    end else if (accept) begin
      if (cmd == CMD_DATA) begin
        phase <= phase_next;
      end
      line_len <= len_f;
      lines    <= lines_f;
      max_line <= max_f;
      zeros    <= zeros_f;
      written  <= written_f;
      last_lf  <= last_f;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bdat_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdat_queue
// Short record queue that decouples the front and back halves.
// ----------------------------------------------------------------------------
module bdat_queue import bdat_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire rec_t push_rec,
  input  wire logic pop,
  output rec_t      head_rec,
  output logic      full,
  output logic      empty
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  rec_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full     = (count == CntW'(Depth));
  assign empty    = (count == '0);
  assign head_rec = mem[rd_ptr];

  // Store records
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bdat_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bdat_back
// Expands each queued record into its results, one per cycle while the
// output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module bdat_back import bdat_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire rec_t        head_rec,
  input  wire logic        empty,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_end,
  output logic [7:0]       out_byte,
  output logic [1:0]       end_status,
  output logic [31:0]      line_count,
  output logic [30:0]      longest_line,
  output logic [31:0]      zero_count,
  output logic [31:0]      total_size,
  output logic             last_of_run
);

  logic [1:0] sub;
  logic [1:0] total;
  logic       load, last, byte_res;

  always_comb begin
    total    = head_rec.nbytes + {1'b0, head_rec.has_end};
    load     = !empty && (!out_valid || !out_stall);
    last     = (sub == total - 2'd1);
    pop      = load && last;
    byte_res = (sub < head_rec.nbytes);
  end

  // Step through the results of the head record
  always_ff @(posedge clk) begin
    if (rst) begin
      sub       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        sub       <= last ? 2'd0 : sub + 2'd1;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the output transaction
  always_ff @(posedge clk) begin
    if (load) begin
      last_of_run <= last;
      if (byte_res) begin
        is_end       <= 1'b0;
        out_byte     <= (sub == 2'd0) ? head_rec.byte0 : head_rec.byte1;
        end_status   <= ST_DONE;
        line_count   <= '0;
        longest_line <= '0;
        zero_count   <= '0;
        total_size   <= '0;
      end else begin
        is_end       <= 1'b1;
        out_byte     <= '0;
        end_status   <= head_rec.status;
        line_count   <= head_rec.cnt.lines;
        longest_line <= head_rec.cnt.longest;
        zero_count   <= head_rec.cnt.zeros;
        total_size   <= head_rec.cnt.size;
      end
    end
  end

endmodule
`default_nettype wire

// ===== verif/bdat_line_ending_normalizer_tb.sv =====
// ----------------------------------------------------------------------------
// bdat_line_ending_normalizer_tb
// Self-checking bench for the chunked-body line-ending normalizer. A local
// normalizer predicts every spool byte and message end status, including the
// counters carried with each end. Directed cases cover line endings, message
// ends and the size limit. Random whole messages follow, with noise mixed in,
// under several size limits and random gaps on both handshakes.
// ----------------------------------------------------------------------------
module bdat_line_ending_normalizer_tb;
  import bdat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    PH_AFTER_LF = 2'd0,
    PH_MID      = 2'd1,
    PH_AFTER_CR = 2'd2
  } line_phase_t;

  // One spool byte or message end, as seen on the output port
  typedef struct packed {
    logic        is_end;
    logic [7:0]  data;
    status_t     status;
    logic [31:0] lines;
    logic [30:0] longest;
    logic [31:0] zeros;
    logic [31:0] total;
    logic        last;
  } spool_res_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [30:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  command;
  logic [7:0]  data_byte;
  logic        out_valid;
  logic        out_stall;
  logic        is_end;
  logic [7:0]  out_byte;
  logic [1:0]  end_status;
  logic [31:0] line_count;
  logic [30:0] longest_line;
  logic [31:0] zero_count;
  logic [31:0] total_size;
  logic        last_of_run;

  // Normalizer state mirrored by the bench
  line_phase_t norm_phase;
  logic [30:0] norm_line_len;
  logic [31:0] norm_lines;
  logic [30:0] norm_max_line;
  logic [31:0] norm_zeros;
  logic [31:0] norm_written;
  logic        norm_last_lf;
  logic [30:0] norm_limit;

  spool_res_t spool_results[$];
  spool_res_t step_res[3];
  int         step_n;
  int         mismatches;
  int         results_seen;
  int         sent_count;
  bit         no_idle;

  bdat_line_ending_normalizer dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_end       (is_end),
    .out_byte     (out_byte),
    .end_status   (end_status),
    .line_count   (line_count),
    .longest_line (longest_line),
    .zero_count   (zero_count),
    .total_size   (total_size),
    .last_of_run  (last_of_run)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Abort a hung run
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  task automatic clear_message();
    norm_phase    = PH_AFTER_LF;
    norm_line_len = '0;
    norm_lines    = '0;
    norm_max_line = '0;
    norm_zeros    = '0;
    norm_written  = '0;
    norm_last_lf  = 1'b1;
  endtask

  task automatic close_line();
    if (norm_line_len > norm_max_line) norm_max_line = norm_line_len;
    if (norm_lines != MAX32) norm_lines++;
    norm_line_len = '0;
  endtask

  // Write one spool byte; flag when the size limit is now exceeded
  task automatic put_byte(input logic [7:0] b, output bit over);
    spool_res_t r;
    r = '0;
    r.data = b;
    step_res[step_n] = r;
    step_n++;
    if (norm_written != MAX32) norm_written++;
    norm_last_lf = (b == CH_LF);
    if (b != CH_LF && norm_line_len != MAX31) norm_line_len++;
    over = (norm_written > norm_limit);
  endtask

  task automatic put_end(input status_t s);
    spool_res_t r;
    r = '0;
    r.is_end  = 1'b1;
    r.status  = s;
    r.lines   = norm_lines;
    r.longest = norm_max_line;
    r.zeros   = norm_zeros;
    r.total   = norm_written;
    step_res[step_n] = r;
    step_n++;
    clear_message();
  endtask

  // Work out the results of one accepted transaction and queue them
  task automatic normalize_step(input cmd_t c, input logic [7:0] b);
    bit over;
    over = 1'b0;
    step_n = 0;
    case (c)
      CMD_CLOSED: put_end(ST_CLOSED);
      CMD_RDERR:  put_end(ST_PROTO);
      CMD_EOD: begin
        // add the missing final line ending
        if (!norm_last_lf) begin
          close_line();
          norm_phase = PH_AFTER_LF;
          put_byte(CH_LF, over);
        end
        put_end(over ? ST_SIZE : ST_DONE);
      end
      default: begin
        if (b == CH_NUL && norm_zeros != MAX32) norm_zeros++;
        if (norm_phase == PH_AFTER_CR) begin
          close_line();
          if (b == CH_LF) begin
            norm_phase = PH_AFTER_LF;
            put_byte(CH_LF, over);
            if (over) put_end(ST_SIZE);
          end else begin
            put_byte(CH_LF, over);
            if (over) begin
              put_end(ST_SIZE);
            end else if (b != CH_CR) begin
              norm_phase = PH_MID;
              put_byte(b, over);
              if (over) put_end(ST_SIZE);
            end
          end
        end else if (b == CH_LF) begin
          close_line();
          norm_phase = PH_AFTER_LF;
          put_byte(CH_LF, over);
          if (over) put_end(ST_SIZE);
        end else if (b == CH_CR) begin
          norm_phase = PH_AFTER_CR;
        end else begin
          norm_phase = PH_MID;
          put_byte(b, over);
          if (over) put_end(ST_SIZE);
        end
      end
    endcase
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
    for (int i = 0; i < step_n; i++) spool_results.push_back(step_res[i]);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  function automatic string fmt_res(spool_res_t r);
    return $sformatf("end=%0b byte=%h st=%0d lines=%0d long=%0d zeros=%0d size=%0d last=%0b",
                     r.is_end, r.data, r.status, r.lines, r.longest, r.zeros, r.total, r.last);
  endfunction

  task automatic check_result();
    spool_res_t got;
    spool_res_t want;
    got.is_end  = is_end;
    got.data    = out_byte;
    got.status  = status_t'(end_status);
    got.lines   = line_count;
    got.longest = longest_line;
    got.zeros   = zero_count;
    got.total   = total_size;
    got.last    = last_of_run;
    results_seen++;
    if (spool_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d arrived with nothing expected: %s", results_seen, fmt_res(got));
    end else begin
      want = spool_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result %0d mismatch", results_seen);
          $display("  expected %s", fmt_res(want));
          $display("  actual   %s", fmt_res(got));
        end
      end
    end
  endtask

  // Predict on input transactions, check output transactions
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) normalize_step(cmd_t'(command), data_byte);
      if (out_valid && !out_stall) check_result();
    end
  end

  // --------------------------------------------------------------------------
  // Idling
  // --------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Stall the output side in random bursts
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      n = idle_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Drive one transaction and hold it until accepted; valid stays high on return
  task automatic send_item(input cmd_t c, input logic [7:0] b);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    command   <= c;
    data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(CMD_DATA, s[i]);
  endtask

  // Drop valid and wait for every expected result, then let the pipe settle
  task automatic wait_idle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (spool_results.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limit(input logic [30:0] v);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    norm_limit = v;
  endtask

  function automatic logic [7:0] body_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(32, 126));
    if (r < 80) return CH_NUL;
    return 8'($urandom_range(0, 255));
  endfunction

  // One well-formed message: lines with mixed endings, then a terminator
  task automatic send_message();
    int n_lines;
    int kind;
    n_lines = $urandom_range(0, 4);
    for (int i = 0; i < n_lines; i++) begin
      repeat ($urandom_range(0, 8)) send_item(CMD_DATA, body_byte());
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        send_item(CMD_DATA, CH_CR);
        send_item(CMD_DATA, CH_LF);
      end else if (kind < 7) begin
        send_item(CMD_DATA, CH_LF);
      end else if (kind < 9) begin
        send_item(CMD_DATA, CH_CR);
      end
    end
    kind = $urandom_range(0, 9);
    if (kind < 8) send_item(CMD_EOD, 8'($urandom_range(0, 255)));
    else if (kind < 9) send_item(CMD_CLOSED, 8'($urandom_range(0, 255)));
    else send_item(CMD_RDERR, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6))
      send_item(cmd_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Line endings, byte extremes and every way a message ends
  task automatic test_line_endings();
    send_item(CMD_DATA, 8'h61);
    send_item(CMD_DATA, 8'hFF);
    send_item(CMD_DATA, CH_NUL);
    send_item(CMD_DATA, CH_LF);
    // CRLF, bare CR, then CR CR left pending at end of data
    send_item(CMD_DATA, 8'h62);
    send_item(CMD_DATA, CH_CR);
    send_item(CMD_DATA, CH_LF);
    send_item(CMD_DATA, 8'h63);
    send_item(CMD_DATA, CH_CR);
    send_item(CMD_DATA, 8'h64);
    send_item(CMD_DATA, CH_CR);
    send_item(CMD_DATA, CH_CR);
    send_item(CMD_EOD, 8'h00);
    // missing final line ending, then an empty message
    send_text("e");
    send_item(CMD_EOD, 8'hFF);
    send_item(CMD_EOD, 8'h00);
    send_text("x");
    send_item(CMD_CLOSED, 8'hA5);
    send_text("y");
    send_item(CMD_RDERR, 8'h5A);
    send_text("z");
    send_item(CMD_DATA, CH_CR);
    send_item(CMD_EOD, 8'h3C);
  endtask

  // Size limit hit by plain bytes, inserted LF and end-of-data LF
  task automatic test_size_limit();
    set_limit(31'd0);
    send_text("a");
    set_limit(31'd2);
    send_text("a");
    send_item(CMD_DATA, CH_CR);
    send_text("b");
    set_limit(31'd2);
    send_text("ab");
    send_item(CMD_DATA, CH_CR);
    send_text("c");
    set_limit(31'd3);
    send_text("ab");
    send_item(CMD_EOD, 8'h00);
    set_limit(31'd2);
    send_text("ab");
    send_item(CMD_EOD, 8'h00);
    set_limit(31'd1);
    send_item(CMD_DATA, CH_LF);
    send_item(CMD_DATA, CH_CR);
    send_item(CMD_DATA, CH_LF);
    send_item(CMD_EOD, 8'h00);
  endtask

  // Random messages under a range of size limits
  task automatic test_random_messages();
    logic [30:0] limits[4];
    int          target;
    bit          paused;
    limits[0] = MAX31;
    limits[1] = 31'($urandom_range(4, 30));
    limits[2] = 31'($urandom_range(0, 3));
    limits[3] = SIZE_LIMIT_RESET;
    for (int p = 0; p < 4; p++) begin
      set_limit(limits[p]);
      no_idle = (p == 1);
      target = sent_count + 75;
      paused = 1'b0;
      while (sent_count < target) begin
        if ($urandom_range(0, 9) == 0) send_noise();
        else send_message();
        // hold the sender once until the output has caught up
        if (p == 0 && !paused && sent_count >= target - 40) begin
          wait_idle();
          paused = 1'b1;
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_valid    <= 1'b0;
    command     <= CMD_DATA;
    data_byte   <= '0;
    no_idle      = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    sent_count   = 0;
    norm_limit   = SIZE_LIMIT_RESET;
    clear_message();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    test_line_endings();
    test_size_limit();
    test_random_messages();

    wait_idle();
    if (spool_results.size() != 0) begin
      $display("%0d expected results never arrived", spool_results.size());
      mismatches += spool_results.size();
    end
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bdat_pkg.sv
hw/rtl/bdat_front.sv
hw/rtl/bdat_queue.sv
hw/rtl/bdat_back.sv
hw/rtl/bdat_line_ending_normalizer.sv
verif/bdat_line_ending_normalizer_tb.sv
